@@ rtl/bbs_pkg.sv @@
// Shared types, constants and control structs for the button and battery supervisor.
// Depends on nothing; every other file of the block imports it.
package bbs_pkg;

	localparam int TIME_BITS = 32;
	localparam int MV_BITS = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int ACC_BITS = 2 * MV_BITS;
	localparam int DIV_STEPS = ACC_BITS;
	localparam int STEP_BITS = $clog2(DIV_STEPS);

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [MV_BITS-1:0] mv_t;
	typedef logic [ACC_BITS-1:0] acc_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	typedef logic [STEP_BITS-1:0] step_t;

	// Register indexes of the configuration port.
	localparam cfg_idx_t REG_PERIOD = 3'd0;
	localparam cfg_idx_t REG_OK = 3'd1;
	localparam cfg_idx_t REG_LOW = 3'd2;
	localparam cfg_idx_t REG_CRITICAL = 3'd3;
	localparam cfg_idx_t REG_HOLD = 3'd4;

	localparam mv_t PERIOD_RESET = 16'd2500;
	localparam mv_t OK_RESET = 16'd6000;
	localparam mv_t LOW_RESET = 16'd5400;
	localparam mv_t CRITICAL_RESET = 16'd4800;
	localparam mv_t HOLD_RESET = 16'd5000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic mul_lo;
		logic mul_hi;
		logic div_step;
		logic finish;
	} bbs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic first;
	} bbs_stat_t;

	// One configuration write as seen by the datapath.
	typedef struct packed {
		logic we;
		cfg_idx_t index;
		mv_t data;
	} bbs_cfg_wr_t;

endpackage

@@ rtl/bbs_tick_if.sv @@
// Input channel carrying one tick beat: timestamp, button level and battery sample.
// Depends on bbs_pkg.
interface bbs_tick_if;
	import bbs_pkg::*;

	logic valid;
	logic ready;
	time_t now_ms;
	logic button_down;
	mv_t sample_mv;

	modport source (output valid, output now_ms, output button_down, output sample_mv,
		input ready);
	modport sink (input valid, input now_ms, input button_down, input sample_mv,
		output ready);
endinterface

@@ rtl/bbs_res_if.sv @@
// Output channel carrying one result beat per tick: average and status bits.
// Depends on bbs_pkg.
interface bbs_res_if;
	import bbs_pkg::*;

	logic valid;
	logic ready;
	mv_t avg_mv;
	logic pressed_flag;
	logic low_flag;
	logic stop_request;
	logic power_off;

	modport source (output valid, output avg_mv, output pressed_flag, output low_flag,
		output stop_request, output power_off, input ready);
	modport sink (input valid, input avg_mv, input pressed_flag, input low_flag,
		input stop_request, input power_off, output ready);
endinterface

@@ rtl/bbs_cfg_if.sv @@
// Configuration write channel: register index and write data with valid and ready.
// Depends on bbs_pkg.
interface bbs_cfg_if;
	import bbs_pkg::*;

	logic valid;
	logic ready;
	cfg_idx_t index;
	mv_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/bbs_ctrl.sv @@
// Controller state machine: sequences accept, two multiply steps, the divider and the
// result hand-off. Depends on bbs_pkg.
module bbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bbs_pkg::bbs_stat_t stat,
	output bbs_pkg::bbs_cmd_t  cmd
);
	import bbs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL_LO = 3'd1;
	localparam logic [2:0] ST_MUL_HI = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	step_t step_q;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.accept = in_valid && (state_q == ST_IDLE);
		cmd.mul_lo = (state_q == ST_MUL_LO);
		cmd.mul_hi = (state_q == ST_MUL_HI);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						// The first tick only loads the average.
						state_q <= stat.first ? ST_DONE : ST_MUL_LO;
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: begin
					state_q <= ST_DIV;
					step_q <= '0;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == step_t'(DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready after an accepted beat");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !cmd.finish)
		else $error("result written over a waiting result");
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_HI) |=> (state_q == ST_DIV && step_q == '0))
		else $error("divider did not start at step zero");
endmodule

@@ rtl/bbs_dp.sv @@
// Datapath: configuration registers, button and battery state, the two multiply steps,
// the restoring divider and the result register. Depends on bbs_pkg.
module bbs_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  bbs_pkg::bbs_cmd_t    cmd,
	output bbs_pkg::bbs_stat_t   stat,
	input  bbs_pkg::bbs_cfg_wr_t cfg_wr,
	input  bbs_pkg::time_t       now_ms,
	input  logic                button_down,
	input  bbs_pkg::mv_t         sample_mv,
	output bbs_pkg::mv_t         avg_mv,
	output logic                pressed_flag,
	output logic                low_flag,
	output logic                stop_request,
	output logic                power_off
);
	import bbs_pkg::*;

	mv_t period_q, ok_q, low_mv_q, critical_q, hold_q;

	mv_t avg_q;
	logic avg_valid_q;
	time_t last_q;
	logic held_q;
	time_t press_start_q;
	logic low_q;
	logic off_q;
	logic stop_q;

	mv_t sample_q;
	mv_t i_q;
	mv_t p_q;
	acc_t prod_q;
	acc_t quo_q;
	mv_t rem_q;

	mv_t res_avg_q;
	logic res_pressed_q, res_low_q, res_stop_q, res_off_q;

	mv_t p_eff;
	time_t interval;
	time_t press_len;
	acc_t mul_a;
	acc_t mul_b;
	logic [MV_BITS:0] trial;
	logic [MV_BITS:0] trial_diff;
	logic ge;
	mv_t new_avg;
	logic crit_hit;
	logic new_low;

	assign stat.first = !avg_valid_q;

	assign p_eff = (period_q == '0) ? mv_t'(1) : period_q;
	assign interval = now_ms - last_q;
	assign press_len = now_ms - press_start_q;

	assign mul_a = ACC_BITS'(avg_q) * ACC_BITS'(p_q - i_q);
	assign mul_b = ACC_BITS'(sample_q) * ACC_BITS'(i_q);

	// One bit of restoring division per cycle.
	assign trial = {rem_q, quo_q[ACC_BITS-1]};
	assign trial_diff = trial - {1'b0, p_q};
	assign ge = (trial >= {1'b0, p_q});

	assign new_avg = avg_valid_q ? quo_q[MV_BITS-1:0] : sample_q;
	assign crit_hit = (new_avg <= critical_q);
	always_comb begin
		new_low = low_q;
		if (new_avg <= low_mv_q) begin
			new_low = 1'b1;
		end else if (new_avg >= ok_q) begin
			new_low = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			ok_q <= OK_RESET;
			low_mv_q <= LOW_RESET;
			critical_q <= CRITICAL_RESET;
			hold_q <= HOLD_RESET;
		end else if (cfg_wr.we) begin
			case (cfg_wr.index)
				REG_PERIOD: period_q <= cfg_wr.data;
				REG_OK: ok_q <= cfg_wr.data;
				REG_LOW: low_mv_q <= cfg_wr.data;
				REG_CRITICAL: critical_q <= cfg_wr.data;
				REG_HOLD: hold_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
			avg_valid_q <= 1'b0;
			last_q <= '0;
			held_q <= 1'b0;
			press_start_q <= '0;
			low_q <= 1'b0;
			off_q <= 1'b0;
			stop_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				stop_q <= 1'b0;
				if (button_down) begin
					if (held_q) begin
						if (press_len > TIME_BITS'(hold_q)) begin
							off_q <= 1'b1;
						end
					end else begin
						press_start_q <= now_ms;
						held_q <= 1'b1;
						stop_q <= 1'b1;
					end
				end else begin
					held_q <= 1'b0;
				end
				last_q <= now_ms;
			end
			if (cmd.finish) begin
				avg_q <= new_avg;
				avg_valid_q <= 1'b1;
				low_q <= new_low;
				if (crit_hit) begin
					off_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample_mv;
			p_q <= p_eff;
			i_q <= (interval > TIME_BITS'(p_eff)) ? p_eff : interval[MV_BITS-1:0];
		end
		if (cmd.mul_lo) begin
			prod_q <= mul_a;
		end
		if (cmd.mul_hi) begin
			quo_q <= prod_q + mul_b;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[ACC_BITS-2:0], ge};
			rem_q <= ge ? trial_diff[MV_BITS-1:0] : trial[MV_BITS-1:0];
		end
		if (cmd.finish) begin
			res_avg_q <= new_avg;
			res_pressed_q <= held_q;
			res_low_q <= new_low;
			res_stop_q <= stop_q;
			res_off_q <= off_q || crit_hit;
		end
	end

	assign avg_mv = res_avg_q;
	assign pressed_flag = res_pressed_q;
	assign low_flag = res_low_q;
	assign stop_request = res_stop_q;
	assign power_off = res_off_q;

	a_off_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		off_q |=> off_q)
		else $error("power-off latch cleared without reset");
	a_avg_only_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> ($stable(avg_q) && $stable(low_q)))
		else $error("average or low flag changed outside of finish");
	a_stop_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |-> held_q)
		else $error("stop request without a held button");
endmodule

@@ rtl/button_and_battery_supervisor.sv @@
// Button and battery supervisor, top level: one result beat for every tick beat.
// First tick after reset: goes straight from accept to the hand-off state; it only loads the average.
// Other ticks: result valid follows the two multiply steps, the 32-step restoring divider
// and the hand-off state; a new tick is taken only once the last result has been handed
// off. A finished result waits in an output register while the next tick is taken.
// Asynchronous active-low reset clears the control and supervisor state and reloads the
// register defaults (working and result registers are not reset); configuration writes are taken in every cycle.
module button_and_battery_supervisor (
	input logic   clk,
	input logic   arst_n,
	bbs_tick_if.sink   tick,
	bbs_res_if.source  res,
	bbs_cfg_if.sink    cfg
);
	import bbs_pkg::*;

	bbs_cmd_t cmd;
	bbs_stat_t stat;
	bbs_cfg_wr_t cfg_wr;

	// The register file never stalls a write.
	assign cfg.ready = 1'b1;
	assign cfg_wr.we = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data = cfg.data;

	// The controller decides when a tick beat is taken and when the result register
	// is loaded; the datapath holds the arithmetic and the supervisor state.
	bbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath handles the button at accept time, then runs the weighted average
	// as two multiplies, an add and a bit-serial divide by the period.
	bbs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr       (cfg_wr),
		.now_ms       (tick.now_ms),
		.button_down  (tick.button_down),
		.sample_mv    (tick.sample_mv),
		.avg_mv       (res.avg_mv),
		.pressed_flag (res.pressed_flag),
		.low_flag     (res.low_flag),
		.stop_request (res.stop_request),
		.power_off    (res.power_off)
	);
endmodule

@@ tb/tb_button_and_battery_supervisor.sv @@
// Self-checking testbench for the button and battery supervisor: drives tick beats and
// register writes, predicts every status beat and compares it field by field.
// Depends on bbs_pkg and the tick, result and configuration interfaces of the block.
module tb_button_and_battery_supervisor;
	timeunit 1ns;
	timeprecision 1ps;
	import bbs_pkg::*;

	// Index outside the register map; a write to it must change nothing.
	localparam cfg_idx_t REG_UNUSED = 3'd7;
	// Presses are released before they run this long while power-off must stay clear.
	localparam time_t SAFE_HOLD_MS = 32'd60000;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_TICKS = 220;
	localparam int LATCHED_TICKS = 200;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 50;

	typedef struct packed {
		mv_t avg_mv;
		logic pressed_flag;
		logic low_flag;
		logic stop_request;
		logic power_off;
	} status_t;

	// Predicts the status beat of every tick and keeps the beats still owed by the block.
	class supervisor_scoreboard;
		mv_t period, ok_lvl, low_lvl, crit_lvl, hold;
		mv_t avg;
		bit avg_loaded;
		time_t last_tick;
		bit held;
		time_t press_start;
		bit bat_low;
		bit off;
		status_t owed_status[$];
		int errors, checked, stops, lows, offs;

		function new();
			period = PERIOD_RESET;
			ok_lvl = OK_RESET;
			low_lvl = LOW_RESET;
			crit_lvl = CRITICAL_RESET;
			hold = HOLD_RESET;
			avg = '0;
			avg_loaded = 0;
			last_tick = '0;
			held = 0;
			press_start = '0;
			bat_low = 0;
			off = 0;
			errors = 0;
			checked = 0;
			stops = 0;
			lows = 0;
			offs = 0;
		endfunction

		function int pending();
			return owed_status.size();
		endfunction

		function void write_reg(cfg_idx_t idx, mv_t val);
			case (idx)
				REG_PERIOD: period = val;
				REG_OK: ok_lvl = val;
				REG_LOW: low_lvl = val;
				REG_CRITICAL: crit_lvl = val;
				REG_HOLD: hold = val;
				default: ;
			endcase
		endfunction

		function void note_tick(time_t now, logic down, mv_t reading);
			longint unsigned p, iv, acc;
			time_t dt;
			logic stop;
			stop = 1'b0;
			// Button first: a new press asks for a stop, a long hold latches power-off.
			if (down) begin
				if (held) begin
					dt = now - press_start;
					if (dt > time_t'(hold))
						off = 1;
				end else begin
					press_start = now;
					held = 1;
					stop = 1'b1;
				end
			end else begin
				held = 0;
			end
			// Then the battery: time-weighted average with the interval capped at the period.
			p = (period == 0) ? 1 : longint'(period);
			dt = now - last_tick;
			iv = longint'(dt);
			last_tick = now;
			if (!avg_loaded) begin
				avg = reading;
				avg_loaded = 1;
			end else begin
				if (iv > p)
					iv = p;
				acc = longint'(avg) * (p - iv) + longint'(reading) * iv;
				avg = mv_t'(acc / p);
			end
			if (avg <= crit_lvl)
				off = 1;
			if (avg <= low_lvl)
				bat_low = 1;
			else if (avg >= ok_lvl)
				bat_low = 0;
			owed_status.push_back({avg, held, bat_low, stop, off});
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_status(status_t got);
			status_t want;
			if (owed_status.size() == 0) begin
				errors++;
				$display("%0t: status beat with none expected, actual avg_mv %0d", $time,
					got.avg_mv);
				return;
			end
			want = owed_status.pop_front();
			checked++;
			stops += want.stop_request;
			lows += want.low_flag;
			offs += want.power_off;
			compare_field("avg_mv", want.avg_mv, got.avg_mv);
			compare_field("pressed_flag", want.pressed_flag, got.pressed_flag);
			compare_field("low_flag", want.low_flag, got.low_flag);
			compare_field("stop_request", want.stop_request, got.stop_request);
			compare_field("power_off", want.power_off, got.power_off);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bbs_tick_if tick();
	bbs_res_if res();
	bbs_cfg_if cfg();

	button_and_battery_supervisor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick),
		.res(res),
		.cfg(cfg)
	);

	supervisor_scoreboard sb = new();

	// Stimulus-side copy of the timeline and the button, so random presses can be
	// kept short of the hold limit while power-off has to stay clear.
	time_t clock_ms = '0;
	logic gen_down = 1'b0;
	time_t gen_press_start = '0;

	// Shared knobs: quiet turns off idling on both sides; each new burst request makes
	// the result side hold off for a long stretch.
	bit quiet = 0;
	int burst_requests = 0;
	int bursts_served = 0;
	int ticks_sent = 0;
	int writes_done = 0;

	always #2 clk = ~clk;

	// Every accepted status beat goes straight to the scoreboard. Sampling happens in
	// the active region of the edge, so the values are the ones the edge saw.
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			sb.check_status(status_t'({res.avg_mv, res.pressed_flag, res.low_flag,
				res.stop_request, res.power_off}));
	end

	// Result side. Idles now and then, and on request holds ready low for a long
	// stretch while the tick side keeps offering, so the block backs up and stalls.
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (bursts_served < burst_requests) begin
				bursts_served++;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= quiet || ($urandom_range(0, 99) >= 8);
			end
		end
	end

	// Ends the run if no beat of any channel is accepted for too long.
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((tick.valid && tick.ready) || (res.valid && res.ready) ||
					(cfg.valid && cfg.ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// Offers one tick beat and returns at the edge where it is accepted. The valid
	// stays high afterwards so that a following beat can go out back to back.
	task automatic send_tick(time_t now, logic down, mv_t reading);
		cfg.valid <= 1'b0;
		if (!quiet) begin
			while ($urandom_range(0, 99) < 8) begin
				tick.valid <= 1'b0;
				@(posedge clk);
			end
		end
		tick.valid <= 1'b1;
		tick.now_ms <= now;
		tick.button_down <= down;
		tick.sample_mv <= reading;
		@(posedge clk);
		while (!tick.ready)
			@(posedge clk);
		sb.note_tick(now, down, reading);
		ticks_sent++;
	endtask

	task automatic tick_after(time_t gap, logic down, mv_t reading);
		time_t now;
		now = clock_ms + gap;
		if (down && !gen_down)
			gen_press_start = now;
		gen_down = down;
		clock_ms = now;
		send_tick(now, down, reading);
	endtask

	task automatic tick_at(time_t at, logic down, mv_t reading);
		tick_after(at - clock_ms, down, reading);
	endtask

	// Register writes happen only with the block idle: the tick side stops offering
	// and waits until every owed status beat has come out.
	task automatic write_reg(cfg_idx_t idx, mv_t val);
		tick.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		sb.write_reg(idx, val);
		writes_done++;
	endtask

	// Picks a period and thresholds for one random phase. Until power-off has been
	// latched on purpose, the critical level is zero and the hold time is at its top;
	// with every sample at least one the average can then never reach zero.
	task automatic configure_phase(int k, bit latched);
		int unsigned per, lowv, okv;
		case ($urandom_range(0, 5))
			0: per = 0;
			1: per = 1;
			2: per = 16'hFFFF;
			default: per = $urandom_range(2, 3000);
		endcase
		lowv = $urandom_range(1000, 64000);
		if ($urandom_range(0, 4) == 0)
			okv = lowv - $urandom_range(0, 1000);
		else
			okv = lowv + $urandom_range(0, 1500);
		if (k == 1) begin
			lowv = 0;
			okv = 16'hFFFF;
		end
		write_reg(REG_PERIOD, mv_t'(per));
		write_reg(REG_OK, mv_t'(okv));
		write_reg(REG_LOW, mv_t'(lowv));
		write_reg(REG_CRITICAL, latched ? mv_t'($urandom_range(0, 65535)) : mv_t'(0));
		write_reg(REG_HOLD, latched ? mv_t'($urandom_range(0, 65535)) : mv_t'(16'hFFFF));
	endtask

	// One random tick. Intervals are mostly short, sometimes around the period and
	// sometimes huge so the timestamp wraps. Samples mostly sit near the low level so
	// the hysteresis flag keeps moving.
	task automatic random_tick(bit latched);
		time_t gap, now;
		int unsigned roll, lo, hi;
		logic down;
		mv_t reading;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			gap = $urandom_range(0, 100);
		else if (roll < 94)
			gap = $urandom_range(0, 2 * sb.period + 2);
		else
			gap = $urandom();
		down = gen_down;
		if ($urandom_range(0, 3) == 0)
			down = ~down;
		now = clock_ms + gap;
		if (!latched && down && gen_down && time_t'(now - gen_press_start) > SAFE_HOLD_MS)
			down = 1'b0;
		lo = (sb.low_lvl > 3000) ? sb.low_lvl - 3000 : 1;
		hi = (sb.low_lvl < 62535) ? sb.low_lvl + 3000 : 65535;
		if ($urandom_range(0, 4) != 0)
			reading = mv_t'($urandom_range(lo, hi));
		else
			reading = mv_t'($urandom_range(latched ? 0 : 1, 65535));
		tick_after(gap, down, reading);
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		tick.valid <= 1'b0;
		tick.now_ms <= '0;
		tick.button_down <= 1'b0;
		tick.sample_mv <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_PERIOD;
		cfg.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A write outside the register map must leave every register alone.
		write_reg(REG_UNUSED, 16'hFFFF);

		// Directed part, reset defaults. The first tick loads the sample as it is.
		tick_at(32'd100, 1'b0, 16'd7000);
		// A gap beyond the period gives the sample full weight.
		tick_after(32'd5000, 1'b0, 16'd6000);
		// Half weight pulls the average to 5000, below the low level.
		tick_after(32'd1250, 1'b0, 16'd4000);
		// Exactly at the low level, then between the levels: the flag stays set.
		tick_after(32'd1250, 1'b0, 16'd5800);
		tick_after(32'd2500, 1'b0, 16'd5999);
		// At the ok level the flag clears.
		tick_after(32'd2500, 1'b0, 16'd6000);
		// A repeated timestamp leaves the average where it is.
		tick_after(32'd0, 1'b0, 16'd100);
		// Smallest steps with the extreme samples.
		tick_after(32'd1, 1'b0, 16'd0);
		tick_after(32'd1, 1'b0, 16'hFFFF);
		// A new press, a hold of exactly the hold time, release and a second press.
		tick_after(32'd50, 1'b1, 16'd6000);
		tick_after(32'd5000, 1'b1, 16'd6000);
		tick_after(32'd20, 1'b0, 16'd6000);
		tick_after(32'd20, 1'b1, 16'd6000);
		tick_after(32'd20, 1'b0, 16'd6000);
		// A press just before the timestamp wraps, still held just after it.
		tick_at(32'hFFFF_FFF0, 1'b1, 16'd6000);
		tick_at(32'h0000_0010, 1'b1, 16'd6000);
		tick_after(32'd10, 1'b0, 16'd6000);
		// A zero period behaves as one, so the sample is taken as it is.
		write_reg(REG_PERIOD, 16'd0);
		tick_after(32'd5, 1'b0, 16'd6100);
		// Widest period with the top timestamp, then a single millisecond.
		write_reg(REG_PERIOD, 16'hFFFF);
		tick_at(32'hFFFF_FFFF, 1'b0, 16'hFFFF);
		tick_after(32'd1, 1'b0, 16'd5000);
		// Crossed levels: the set test wins, otherwise the clear test applies.
		write_reg(REG_CRITICAL, 16'd0);
		write_reg(REG_LOW, 16'd7000);
		write_reg(REG_OK, 16'd5000);
		tick_after(32'd65535, 1'b0, 16'd6500);
		tick_after(32'd65535, 1'b0, 16'd7001);
		// Extreme levels in both directions.
		write_reg(REG_LOW, 16'd0);
		write_reg(REG_OK, 16'hFFFF);
		write_reg(REG_PERIOD, 16'd1);
		tick_after(32'd3, 1'b0, 16'd30000);
		write_reg(REG_LOW, 16'hFFFF);
		write_reg(REG_OK, 16'd0);
		tick_after(32'd1, 1'b0, 16'd40000);

		// Random phases with power-off kept clear. The third starts with a long
		// hold-off on the result side, the fifth runs without any idling.
		for (int k = 0; k < RANDOM_PHASES; k++) begin
			configure_phase(k, 1'b0);
			if (k == 2)
				burst_requests++;
			quiet = (k == 4);
			repeat (PHASE_TICKS) random_tick(1'b0);
		end
		quiet = 0;

		// The power-off latch comes last, since only reset clears it. First the
		// boundaries that must not latch: a hold of exactly the hold time, a zero hold
		// with a repeated timestamp, an average one above the critical level.
		write_reg(REG_PERIOD, PERIOD_RESET);
		write_reg(REG_OK, OK_RESET);
		write_reg(REG_LOW, LOW_RESET);
		write_reg(REG_HOLD, 16'd100);
		tick_after(32'd3000, 1'b0, 16'd6000);
		tick_after(32'd10, 1'b1, 16'd6000);
		tick_after(32'd100, 1'b1, 16'd6000);
		tick_after(32'd0, 1'b0, 16'd6000);
		write_reg(REG_HOLD, 16'd0);
		tick_after(32'd10, 1'b1, 16'd6000);
		tick_after(32'd0, 1'b1, 16'd6000);
		tick_after(32'd5, 1'b0, 16'd6000);
		write_reg(REG_CRITICAL, 16'd5999);
		tick_after(32'd0, 1'b0, 16'd6000);
		// An average equal to the critical level latches power-off.
		write_reg(REG_CRITICAL, 16'd6000);
		tick_after(32'd0, 1'b0, 16'd6000);
		// Processing goes on with the latch set: a long hold and a low reading.
		tick_after(32'd10, 1'b1, 16'd6000);
		tick_after(32'd200, 1'b1, 16'd6000);
		tick_after(32'd3000, 1'b0, 16'd3000);

		configure_phase(RANDOM_PHASES, 1'b1);
		repeat (LATCHED_TICKS) random_tick(1'b1);

		tick.valid <= 1'b0;
		for (int n = 0; n < STALL_LIMIT && sb.pending() != 0; n++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: %0d status beats never arrived", $time, sb.pending());
		end

		$display("Covered %0d ticks and %0d register writes over %0d random phases.",
			ticks_sent, writes_done, RANDOM_PHASES + 1);
		$display("Checked %0d status beats: %0d new presses, %0d low, %0d with power-off.",
			sb.checked, sb.stops, sb.lows, sb.offs);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
